FILE: hdl/assert_macros.svh
// Assertion macros used by the heap engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/edf_pkg.sv
// Types and constants shared by the scheduler modules.
package edf_pkg;

  localparam int DAY_FIELD_W   = 16;
  localparam int COUNT_FIELD_W = 11;
  localparam int DAY_W         = 17;

  typedef struct packed {
    logic [DAY_FIELD_W-1:0] start_day;
    logic [DAY_FIELD_W-1:0] end_day;
    logic                   last_event;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_FIELD_W-1:0] attended_count;
    logic                     capacity_exceeded;
  } out_item_t;

  // Command to a heap engine; at most one of ins and rem is set.
  typedef struct packed {
    logic ins;
    logic rem;
    logic clr;
  } heap_cmd_t;

endpackage

FILE: hdl/edf_heap.sv
// Min-heap engine: one memory with sift-up insert, sift-down remove and clear.
`include "assert_macros.svh"

module edf_heap #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 16,
  parameter int CNT_W  = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  edf_pkg::heap_cmd_t cmd,
  input  logic [DATA_W-1:0] ins_val,
  output logic              busy,
  output logic [CNT_W-1:0]  count,
  output logic [DATA_W-1:0] top
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] H_IDLE     = 3'd0;
  localparam logic [2:0] H_INS      = 3'd1;
  localparam logic [2:0] H_INS_CMP  = 3'd2;
  localparam logic [2:0] H_REM_LAST = 3'd3;
  localparam logic [2:0] H_REM      = 3'd4;
  localparam logic [2:0] H_REM_CMP  = 3'd5;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_a_r, rd_b_r;
  logic [IDX_W-1:0]  rd_a_addr, rd_b_addr;
  logic              rd_en;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  par_r, par_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [DATA_W-1:0] top_r;
  logic [CNT_W:0]    child;
  logic [CNT_W:0]    child_r, child_nxt;
  logic              take_right;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_a_addr];
      rd_b_r <= mem[rd_b_addr];
    end
    if (wr_en && wr_addr == '0) begin
      top_r <= wr_data;
    end
  end

  assign child      = {idx_r, 1'b1};
  assign take_right = ((child_r + 1'b1) < {1'b0, cnt_r}) && (rd_b_r < rd_a_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    par_nxt   = par_r;
    val_nxt   = val_r;
    child_nxt = child_r;
    rd_en     = 1'b0;
    rd_a_addr = '0;
    rd_b_addr = '0;
    wr_en     = 1'b0;
    wr_addr   = idx_r[IDX_W-1:0];
    wr_data   = val_r;
    unique case (state_r)
      H_IDLE: begin
        if (cmd.clr) begin
          cnt_nxt = '0;
        end else if (cmd.ins) begin
          idx_nxt   = cnt_r;
          cnt_nxt   = cnt_r + 1'b1;
          val_nxt   = ins_val;
          state_nxt = H_INS;
        end else if (cmd.rem && cnt_r != '0) begin
          cnt_nxt   = cnt_r - 1'b1;
          idx_nxt   = '0;
          rd_en     = 1'b1;
          rd_a_addr = IDX_W'(cnt_r - 1'b1);
          state_nxt = H_REM_LAST;
        end
      end
      H_INS: begin
        if (idx_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = H_IDLE;
        end else begin
          par_nxt   = (idx_r - 1'b1) >> 1;
          rd_en     = 1'b1;
          rd_a_addr = IDX_W'((idx_r - 1'b1) >> 1);
          state_nxt = H_INS_CMP;
        end
      end
      H_INS_CMP: begin
        wr_en = 1'b1;
        if (rd_a_r <= val_r) begin
          state_nxt = H_IDLE;
        end else begin
          wr_data   = rd_a_r;
          idx_nxt   = par_r;
          state_nxt = H_INS;
        end
      end
      H_REM_LAST: begin
        val_nxt   = rd_a_r;
        state_nxt = H_REM;
      end
      H_REM: begin
        if (child >= {1'b0, cnt_r}) begin
          wr_en     = (cnt_r != '0);
          state_nxt = H_IDLE;
        end else begin
          child_nxt = child;
          rd_en     = 1'b1;
          rd_a_addr = IDX_W'(child);
          rd_b_addr = IDX_W'(child + 1'b1);
          state_nxt = H_REM_CMP;
        end
      end
      H_REM_CMP: begin
        wr_en = 1'b1;
        if (val_r <= (take_right ? rd_b_r : rd_a_r)) begin
          state_nxt = H_IDLE;
        end else begin
          wr_data   = take_right ? rd_b_r : rd_a_r;
          idx_nxt   = take_right ? CNT_W'(child_r + 1'b1) : CNT_W'(child_r);
          state_nxt = H_REM;
        end
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    idx_r   <= idx_nxt;
    par_r   <= par_nxt;
    val_r   <= val_nxt;
    child_r <= child_nxt;
  end

  assign busy  = (state_r != H_IDLE);
  assign count = cnt_r;
  assign top   = top_r;

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(DEPTH), "heap count over depth")
  `ASSERT_ALWAYS(a_no_cmd_busy, clk, rst_n, !(busy && (cmd.ins || cmd.rem)), "command while busy")
  `ASSERT_NEXT(a_ins_grows, clk, rst_n, state_r == H_IDLE && cmd.ins && !cmd.clr,
    cnt_r == $past(cnt_r) + 1'b1, "insert did not grow the heap")

endmodule

FILE: hdl/edf_unit_event_scheduler.sv
// Top level: event loading and the day-by-day earliest-deadline scheduling loop.
//
//  channel | dir | payload             | handshake
//  in_     | in  | edf_pkg::in_item_t  | in_valid / in_stall
//  out_    | out | edf_pkg::out_item_t | out_valid / out_stall
//
// Loading accepts one event at a time: the release heap sifts each event up
// level by level and then writes it in place, and in_stall is high meanwhile.
// After the last event the day loop runs: each heap removal sifts down level
// by level in its heap engine, and every step of the loop waits for both heaps
// to be idle.
// rst_n is synchronous; both heaps start empty, no clearing pass is needed.
// A finished result waits in the output register while the next set loads.
module edf_unit_event_scheduler #(
  parameter int              MAX_EVENTS = 1024,
  parameter longint unsigned MAX_DAY    = 65535
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  edf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output edf_pkg::out_item_t out_data
);

  localparam int CNT_W = $clog2(MAX_EVENTS + 1);
  localparam int DW    = edf_pkg::DAY_FIELD_W;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_DAY   = 3'd1;
  localparam logic [2:0] S_DROP  = 3'd2;
  localparam logic [2:0] S_REL   = 3'd3;
  localparam logic [2:0] S_SERVE = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]                  state_r, state_nxt;
  logic [edf_pkg::DAY_W-1:0]   day_r, day_nxt, day_eff;
  logic [CNT_W-1:0]            served_r, served_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        out_valid_r, out_valid_nxt;
  edf_pkg::out_item_t          out_r, out_nxt;

  edf_pkg::heap_cmd_t          rel_cmd, dl_cmd;
  logic [2*DW-1:0]             rel_val, rel_top;
  logic [DW-1:0]               dl_val, dl_top;
  logic                        rel_busy, dl_busy, heaps_idle;
  logic [CNT_W-1:0]            rel_cnt, dl_cnt;
  logic [DW-1:0]               s_eff;
  logic                        accept;

  edf_heap #(.DEPTH(MAX_EVENTS), .DATA_W(2*DW), .CNT_W(CNT_W)) u_rel_heap (
    .clk(clk), .rst_n(rst_n), .cmd(rel_cmd), .ins_val(rel_val),
    .busy(rel_busy), .count(rel_cnt), .top(rel_top)
  );

  edf_heap #(.DEPTH(MAX_EVENTS), .DATA_W(DW), .CNT_W(CNT_W)) u_dl_heap (
    .clk(clk), .rst_n(rst_n), .cmd(dl_cmd), .ins_val(dl_val),
    .busy(dl_busy), .count(dl_cnt), .top(dl_top)
  );

  assign heaps_idle = !rel_busy && !dl_busy;
  assign in_stall   = (state_r != S_LOAD) || rel_busy;
  assign accept     = in_valid && !in_stall;
  assign s_eff      = (in_data.start_day == '0) ? DW'(1) : in_data.start_day;
  assign rel_val    = {s_eff, in_data.end_day};
  assign dl_val     = rel_top[DW-1:0];
  assign day_eff    = (dl_cnt == '0 && {1'b0, rel_top[2*DW-1:DW]} > day_r) ?
                      {1'b0, rel_top[2*DW-1:DW]} : day_r;

  always_comb begin
    state_nxt     = state_r;
    day_nxt       = day_r;
    served_nxt    = served_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    rel_cmd       = '0;
    dl_cmd        = '0;
    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (in_data.end_day >= s_eff) begin
            if (rel_cnt < CNT_W'(MAX_EVENTS)) begin
              rel_cmd.ins = 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (in_data.last_event) begin
            day_nxt   = edf_pkg::DAY_W'(1);
            state_nxt = S_DAY;
          end
        end
      end
      S_DAY: begin
        if (heaps_idle) begin
          if (dl_cnt == '0 && rel_cnt == '0) begin
            state_nxt = S_OUT;
          end else if (64'(day_eff) > MAX_DAY) begin
            state_nxt = S_OUT;
          end else begin
            day_nxt   = day_eff;
            state_nxt = S_DROP;
          end
        end
      end
      S_DROP: begin
        if (heaps_idle) begin
          if (dl_cnt != '0 && {1'b0, dl_top} < day_r) begin
            dl_cmd.rem = 1'b1;
          end else begin
            state_nxt = S_REL;
          end
        end
      end
      S_REL: begin
        // The released event's deadline moves across while the release heap sifts down.
        if (heaps_idle) begin
          if (rel_cnt != '0 && {1'b0, rel_top[2*DW-1:DW]} <= day_r) begin
            rel_cmd.rem = 1'b1;
            dl_cmd.ins  = 1'b1;
          end else begin
            state_nxt = S_SERVE;
          end
        end
      end
      S_SERVE: begin
        if (heaps_idle) begin
          if (dl_cnt != '0) begin
            dl_cmd.rem = 1'b1;
            served_nxt = served_r + 1'b1;
          end
          day_nxt   = day_r + 1'b1;
          state_nxt = S_DAY;
        end
      end
      S_OUT: begin
        if (heaps_idle && !(out_valid_r && out_stall)) begin
          out_valid_nxt             = 1'b1;
          out_nxt.attended_count    = edf_pkg::COUNT_FIELD_W'(served_r);
          out_nxt.capacity_exceeded = ovf_r;
          rel_cmd.clr               = 1'b1;
          dl_cmd.clr                = 1'b1;
          served_nxt                = '0;
          ovf_nxt                   = 1'b0;
          day_nxt                   = edf_pkg::DAY_W'(1);
          state_nxt                 = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      day_r       <= edf_pkg::DAY_W'(1);
      served_r    <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      day_r       <= day_nxt;
      served_r    <= served_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: tb/sv/edf_unit_event_scheduler_tb.sv
// Testbench for the earliest-deadline-first unit event scheduler.
module edf_unit_event_scheduler_tb;

  localparam int CAPACITY = 1024;
  localparam int LAST_DAY = 65535;
  localparam longint CYCLE_LIMIT = 60000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  edf_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  edf_pkg::out_item_t out_data;

  edf_unit_event_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Events of the set being loaded, kept as start and end pairs.
  int unsigned set_start[$];
  int unsigned set_end[$];
  bit set_dropped;
  edf_pkg::out_item_t expected_counts[$];

  int errors;
  int sender_idle_pct;
  int stall_pct;
  bit hold_off;
  longint cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Count of events the greedy earliest-deadline walk attends.
  function automatic int unsigned count_attended();
    int unsigned pend_end[$];
    int unsigned rel_s[$];
    int unsigned rel_e[$];
    int unsigned day;
    int unsigned served;
    int best;
    int k;
    served = 0;
    day = 1;
    rel_s = set_start;
    rel_e = set_end;
    forever begin
      if (pend_end.size() == 0) begin
        int unsigned nxt;
        if (rel_s.size() == 0) break;
        nxt = rel_s[0];
        foreach (rel_s[i]) if (rel_s[i] < nxt) nxt = rel_s[i];
        if (nxt > day) day = nxt;
      end
      if (day > LAST_DAY) break;
      for (k = pend_end.size() - 1; k >= 0; k--)
        if (pend_end[k] < day) pend_end.delete(k);
      for (k = rel_s.size() - 1; k >= 0; k--) begin
        if (rel_s[k] <= day) begin
          pend_end = {pend_end, rel_e[k]};
          rel_s.delete(k);
          rel_e.delete(k);
        end
      end
      if (pend_end.size() > 0) begin
        best = 0;
        foreach (pend_end[i]) if (pend_end[i] < pend_end[best]) best = i;
        pend_end.delete(best);
        served++;
      end
      day++;
    end
    return served;
  endfunction

  // Update the set with an accepted event and predict the result when it closes.
  task automatic absorb_event(edf_pkg::in_item_t ev);
    int unsigned s;
    int unsigned e;
    edf_pkg::out_item_t res;
    s = (ev.start_day == 0) ? 1 : ev.start_day;
    e = ev.end_day;
    if (e >= s) begin
      if (set_start.size() < CAPACITY) begin
        set_start = {set_start, s};
        set_end = {set_end, e};
      end else begin
        set_dropped = 1'b1;
      end
    end
    if (ev.last_event) begin
      res.attended_count = edf_pkg::COUNT_FIELD_W'(count_attended());
      res.capacity_exceeded = set_dropped;
      expected_counts = {expected_counts, res};
      set_start.delete();
      set_end.delete();
      set_dropped = 1'b0;
    end
  endtask

  // Valid stays high after an accepted transaction until the sender idles or stops.
  task automatic send_event(logic [15:0] s, logic [15:0] e, logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{start_day: s, end_day: e, last_event: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_event(in_data);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  // Receiver stall pattern, changed at the falling edge.
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    edf_pkg::out_item_t exp_item;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** edf_unit_event_scheduler: FAILED **");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %0d/%0b", $time,
                 out_data.attended_count, out_data.capacity_exceeded);
        errors++;
      end else begin
        exp_item = expected_counts.pop_front();
        if (out_data.attended_count !== exp_item.attended_count) begin
          $display("%0t: attended_count expected %0d actual %0d", $time,
                   exp_item.attended_count, out_data.attended_count);
          errors++;
        end
        if (out_data.capacity_exceeded !== exp_item.capacity_exceeded) begin
          $display("%0t: capacity_exceeded expected %0b actual %0b", $time,
                   exp_item.capacity_exceeded, out_data.capacity_exceeded);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_event(16'd1, 16'd1, 1'b1);
    send_event(16'd0, 16'd0, 1'b1);
    send_event(16'd0, 16'd2, 1'b0);
    send_event(16'd5, 16'd3, 1'b0);
    send_event(16'd1, 16'd1, 1'b1);
    send_event(16'hFFFF, 16'hFFFF, 1'b0);
    send_event(16'hFFFF, 16'hFFFF, 1'b0);
    send_event(16'hFFFE, 16'hFFFF, 1'b1);
    send_event(16'd1, 16'hFFFF, 1'b0);
    send_event(16'h5555, 16'hAAAA, 1'b0);
    send_event(16'hAAAA, 16'hD555, 1'b0);
    send_event(16'd2, 16'd3, 1'b0);
    send_event(16'd2, 16'd3, 1'b0);
    send_event(16'd2, 16'd3, 1'b1);
    drain();
  endtask

  // Random sets; mostly small with narrow day ranges so events contend.
  task automatic random_sets(int n_items);
    int sent;
    int set_len;
    int span;
    int base;
    logic [15:0] s;
    logic [15:0] e;
    sent = 0;
    while (sent < n_items) begin
      set_len = $urandom_range(1, 12);
      span = ($urandom_range(3) == 0) ? 65535 : $urandom_range(1, 40);
      base = $urandom_range(0, 65535 - span);
      for (int i = 0; i < set_len; i++) begin
        s = 16'(base + $urandom_range(0, span));
        e = ($urandom_range(15) == 0) ? 16'($urandom) : 16'(s + $urandom_range(0, 8));
        if (e < s && $urandom_range(3) != 0) e = s;
        send_event(s, e, i == set_len - 1);
      end
      sent += set_len;
    end
  endtask

  task automatic test_idle_phases();
    sender_idle_pct = 0;  stall_pct = 0;  random_sets(40);
    sender_idle_pct = 77; stall_pct = 0;  random_sets(40);
    sender_idle_pct = 0;  stall_pct = 77; random_sets(40);
    sender_idle_pct = 9;  stall_pct = 9;  random_sets(40);
    drain();
  endtask

  // Long receiver hold-off while several sets keep arriving.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        random_sets(60);
        in_valid <= 1'b0;
        @(negedge clk);
      end
      begin
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
      end
    join
    drain();
  endtask

  // Overflow: more than capacity events in one set.
  task automatic test_capacity();
    sender_idle_pct = 0;
    stall_pct = 30;
    for (int i = 0; i < CAPACITY + 2; i++)
      send_event(16'($urandom_range(1, 2000)), 16'($urandom_range(2000, 2100)),
                 i == CAPACITY + 1);
    drain();
  endtask

  initial begin
    errors = 0;
    cycle_count = 0;
    hold_off = 1'b0;
    sender_idle_pct = 0;
    stall_pct = 0;
    set_dropped = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_idle_phases();
    test_backpressure();
    test_capacity();
    drain();
    if (errors == 0 && expected_counts.size() == 0)
      $display("** edf_unit_event_scheduler: PASSED **");
    else
      $display("** edf_unit_event_scheduler: FAILED **");
    $finish;
  end
endmodule

FILE: files.f
+incdir+hdl
hdl/edf_pkg.sv
hdl/edf_heap.sv
hdl/edf_unit_event_scheduler.sv
tb/sv/edf_unit_event_scheduler_tb.sv
